[rtl/rgbhsv_pkg.sv]
`default_nettype none

package rgbhsv_pkg;

  // Channel and result widths
  localparam int CH_W  = 8;
  localparam int HUE_W = 16;
  localparam int SAT_W = 8;

  // Stream payload widths
  localparam int IN_DATA_W  = 3 * CH_W;
  localparam int OUT_DATA_W = HUE_W + SAT_W + CH_W;
  localparam int OUT_USER_W = 1;

  // Internal arithmetic widths
  localparam int NUM_W  = 12;  // hue numerator, up to 11*255
  localparam int DIV_W  = 11;  // 6*delta, up to 1530
  localparam int SATN_W = 17;  // 510*delta + max, up to 130305
  localparam int DEN2_W = 9;   // 2*max

  // Division step counts: one quotient bit per stage
  localparam int HUE_STEPS = HUE_W;
  localparam int SAT_STEPS = SAT_W;

  // Stage count: extrema, numerators, first hue subtract, hue steps
  localparam int NSTG = 3 + HUE_STEPS;

  // Hexcone sector of the largest channel
  localparam logic [1:0] SEC_RED = 2'd0;
  localparam logic [1:0] SEC_GRN = 2'd1;
  localparam logic [1:0] SEC_BLU = 2'd2;

  // After extrema search
  typedef struct packed {
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] delta;
    logic [1:0]      sector;
    logic [CH_W-1:0] pos;
    logic [CH_W-1:0] neg;
    logic            black;
    logic            grey;
  } sect_t;

  // After numerator and divisor build
  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [DIV_W-1:0]  six_d;
    logic [SATN_W-1:0] satn;
    logic [DEN2_W-1:0] two_hi;
    logic [CH_W-1:0]   hi;
    logic              black;
    logic              grey;
  } numr_t;

  // Divider stage: partial remainders and quotients of both divisions
  typedef struct packed {
    logic [DIV_W-1:0]  hue_rem;
    logic [HUE_W-1:0]  hue_q;
    logic [DIV_W-1:0]  six_d;
    logic [DEN2_W-1:0] sat_rem;
    logic [SAT_W-1:0]  sat_low;
    logic [SAT_W-1:0]  sat_q;
    logic [DEN2_W-1:0] two_hi;
    logic [CH_W-1:0]   hi;
    logic              black;
    logic              grey;
  } div_t;

endpackage

`default_nettype wire

[rtl/rgb_to_hsv_converter.sv]
`default_nettype none

// RGB to HSV converter, hexcone model, 8-bit channels. One pixel per clock
// while the output is ready. Between input transfer and output valid, one stage
// finds max/min and the sector, one builds the numerators, one takes the first
// hue subtract, then 16 stages each produce one hue quotient bit by restoring
// division (the first 8 of them also produce the saturation bits). Each stage
// holds on its own handshake, so bubbles close up while the output is stalled.
// Value is the largest channel; saturation is 255*delta/max rounded half up;
// hue is a 0.16 fraction of a turn, floored. Grey gives hue and saturation 0;
// black also sets out_tuser (hue undefined).
module rgb_to_hsv_converter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in
  input  wire logic [rgbhsv_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] hue_out, [23:16] saturation_out, [31:24] value_out
  output logic [rgbhsv_pkg::OUT_DATA_W-1:0]      out_tdata,
  // [0] hue_undefined
  output logic [rgbhsv_pkg::OUT_USER_W-1:0]      out_tuser
);
  import rgbhsv_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;

  sect_t sa_r, sa_nxt;
  numr_t sb_r, sb_nxt;
  div_t  div_r   [0:HUE_STEPS];
  div_t  div_nxt [0:HUE_STEPS];

  logic [CH_W-1:0] red, grn, blu, hi, lo;

  // Per-stage ready: a stage loads when empty or when its successor moves
  assign rdy[NSTG] = out_tready;
  for (genvar i = 0; i < NSTG; i++) begin : g_rdy
    assign rdy[i] = ~vld_r[i] | rdy[i+1];
  end
  assign in_tready = rdy[0];

  assign vld_nxt = (rdy[NSTG-1:0] & {vld_r[NSTG-2:0], in_tvalid}) |
                   (~rdy[NSTG-1:0] & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Stage A: extrema and sector, ties go red first, then green
  assign red = in_tdata[CH_W-1:0];
  assign grn = in_tdata[2*CH_W-1:CH_W];
  assign blu = in_tdata[3*CH_W-1:2*CH_W];

  always_comb begin
    hi = red;
    if (grn > hi) hi = grn;
    if (blu > hi) hi = blu;
    lo = red;
    if (grn < lo) lo = grn;
    if (blu < lo) lo = blu;

    sa_nxt.hi    = hi;
    sa_nxt.delta = hi - lo;
    sa_nxt.black = (hi == '0);
    sa_nxt.grey  = (hi == lo);
    if (red == hi) begin
      sa_nxt.sector = SEC_RED;
      sa_nxt.pos    = grn;
      sa_nxt.neg    = blu;
    end else if (grn == hi) begin
      sa_nxt.sector = SEC_GRN;
      sa_nxt.pos    = blu;
      sa_nxt.neg    = red;
    end else begin
      sa_nxt.sector = SEC_BLU;
      sa_nxt.pos    = red;
      sa_nxt.neg    = grn;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      sa_r <= sa_nxt;
    end
  end

  // Stage B: hue numerator (one turn added, never negative) and sat numerator
  logic [NUM_W-1:0] base_d;
  logic [DIV_W-1:0] six_d;

  always_comb begin
    six_d = DIV_W'({sa_r.delta, 2'b00}) + DIV_W'({sa_r.delta, 1'b0});
    case (sa_r.sector)
      SEC_RED: base_d = '0;
      SEC_GRN: base_d = NUM_W'({sa_r.delta, 1'b0});
      SEC_BLU: base_d = NUM_W'({sa_r.delta, 2'b00});
      default: base_d = '0;
    endcase
    sb_nxt.num    = base_d + NUM_W'(six_d) + NUM_W'(sa_r.pos) - NUM_W'(sa_r.neg);
    sb_nxt.six_d  = six_d;
    sb_nxt.satn   = SATN_W'({sa_r.delta, 9'b0}) - SATN_W'({sa_r.delta, 1'b0}) +
                    SATN_W'(sa_r.hi);
    sb_nxt.two_hi = {sa_r.hi, 1'b0};
    sb_nxt.hi     = sa_r.hi;
    sb_nxt.black  = sa_r.black;
    sb_nxt.grey   = sa_r.grey;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sb_r <= sb_nxt;
    end
  end

  // Stage C: drop the integer turn (num < 2*six_d), seed saturation remainder
  always_comb begin
    if (sb_r.num >= NUM_W'(sb_r.six_d)) begin
      div_nxt[0].hue_rem = DIV_W'(sb_r.num - NUM_W'(sb_r.six_d));
    end else begin
      div_nxt[0].hue_rem = DIV_W'(sb_r.num);
    end
    div_nxt[0].hue_q   = '0;
    div_nxt[0].six_d   = sb_r.six_d;
    div_nxt[0].sat_rem = sb_r.satn[SATN_W-1:SAT_W];
    div_nxt[0].sat_low = sb_r.satn[SAT_W-1:0];
    div_nxt[0].sat_q   = '0;
    div_nxt[0].two_hi  = sb_r.two_hi;
    div_nxt[0].hi      = sb_r.hi;
    div_nxt[0].black   = sb_r.black;
    div_nxt[0].grey    = sb_r.grey;
  end

  // Divider stages: one restoring step per stage
  for (genvar j = 1; j <= HUE_STEPS; j++) begin : g_div
    logic [DIV_W:0]  htry;
    logic            hbit;
    logic [DEN2_W:0] stry;
    logic            sbit;

    assign htry = {div_r[j-1].hue_rem, 1'b0};
    assign hbit = (htry >= {1'b0, div_r[j-1].six_d});
    assign stry = {div_r[j-1].sat_rem, div_r[j-1].sat_low[SAT_W-1]};
    assign sbit = (stry >= {1'b0, div_r[j-1].two_hi});

    always_comb begin
      div_nxt[j] = div_r[j-1];
      if (hbit) begin
        div_nxt[j].hue_rem = DIV_W'(htry - {1'b0, div_r[j-1].six_d});
      end else begin
        div_nxt[j].hue_rem = DIV_W'(htry);
      end
      div_nxt[j].hue_q = {div_r[j-1].hue_q[HUE_W-2:0], hbit};
      // Saturation quotient finishes in the first SAT_STEPS stages
      if (j <= SAT_STEPS) begin
        if (sbit) begin
          div_nxt[j].sat_rem = DEN2_W'(stry - {1'b0, div_r[j-1].two_hi});
        end else begin
          div_nxt[j].sat_rem = DEN2_W'(stry);
        end
        div_nxt[j].sat_low = {div_r[j-1].sat_low[SAT_W-2:0], 1'b0};
        div_nxt[j].sat_q   = {div_r[j-1].sat_q[SAT_W-2:0], sbit};
      end
    end
  end

  for (genvar k = 0; k <= HUE_STEPS; k++) begin : g_dreg
    always_ff @(posedge clk) begin
      if (rdy[k+2]) begin
        div_r[k] <= div_nxt[k];
      end
    end
  end

  // Output: grey and black force hue and saturation to zero
  logic zero_hs;
  assign zero_hs    = div_r[HUE_STEPS].black | div_r[HUE_STEPS].grey;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {div_r[HUE_STEPS].hi,
                       zero_hs ? '0 : div_r[HUE_STEPS].sat_q,
                       zero_hs ? '0 : div_r[HUE_STEPS].hue_q};
  assign out_tuser  = div_r[HUE_STEPS].black;

`ifndef NO_ASSERTIONS
  // Black pixel: everything zero
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("black pixel with nonzero result");

  // Hue defined only when value is nonzero
  a_value_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[OUT_DATA_W-1:HUE_W+SAT_W] != '0)
    else $error("zero value without undefined hue");

  // Zero saturation only for grey, which has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[HUE_W+SAT_W-1:HUE_W] == '0 |-> out_tdata[HUE_W-1:0] == '0)
    else $error("zero saturation with nonzero hue");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> vld_r == '0)
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
